@@ src/ldm_pkg.sv @@
`default_nettype none
package ldm_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] pp_line;
        logic [23:0] orig_line;
        logic [7:0]  file_id;
    } t_in_item;

    typedef struct packed {
        logic signed [25:0] mapped_line;
        logic [7:0]         mapped_file_id;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [23:0] pp_line;
        logic [23:0] orig_line;
        logic [7:0]  file_id;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_CMP,
        S_CALC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic search_init;
        logic step;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_search;
        logic search_go;
    } t_stat;

endpackage
`default_nettype wire

@@ src/ldm_ctrl.sv @@
`default_nettype none
module ldm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ldm_pkg::t_stat i_stat,
    output ldm_pkg::t_cmd      o_cmd
);

    ldm_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ldm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ldm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ldm_pkg::S_EXEC;
                end
            end
            ldm_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.need_search) begin
                    o_cmd.search_init = 1'b1;
                    n_state           = ldm_pkg::S_SEARCH;
                end else begin
                    n_state = ldm_pkg::S_DONE;
                end
            end
            ldm_pkg::S_SEARCH: begin
                // The memory read is issued here; the data is registered and seen in the next state, S_CMP or S_CALC.
                if (i_stat.search_go) begin
                    n_state = ldm_pkg::S_CMP;
                end else begin
                    n_state = ldm_pkg::S_CALC;
                end
            end
            ldm_pkg::S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = ldm_pkg::S_SEARCH;
            end
            ldm_pkg::S_CALC: begin
                o_cmd.finish = 1'b1;
                n_state      = ldm_pkg::S_DONE;
            end
            ldm_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ldm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ldm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ src/ldm_datapath.sv @@
`default_nettype none
module ldm_datapath #(
    parameter int TABLE_DEPTH = ldm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [7:0]        i_cfg_wr_data,
    input  wire ldm_pkg::t_in_item i_in_data,
    input  wire ldm_pkg::t_cmd     i_cmd,
    output ldm_pkg::t_stat         o_stat,
    output ldm_pkg::t_out_item     o_out_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    ldm_pkg::t_entry    r_mem [TABLE_DEPTH];
    ldm_pkg::t_entry    r_rd_data;
    ldm_pkg::t_in_item  r_item;
    ldm_pkg::t_out_item r_res, r_out, n_res_exec, n_res_fin;
    logic [CW-1:0]      r_count, w_last_idx;
    logic [23:0]        r_last_pp, r_first_pp, w_diff;
    logic [7:0]         r_base_fid;
    logic [IW-1:0]      r_lo, r_hi, w_mid, w_rd_addr;
    logic [IW:0]        w_sum;
    logic               w_empty, w_direct, w_order_err, w_full, w_add_ok, w_search_go;

    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi} + {{IW{1'b0}}, 1'b1};
    assign w_mid       = w_sum[IW:1];
    assign w_search_go = r_lo < r_hi;
    assign w_rd_addr   = w_search_go ? w_mid : r_lo;
    assign w_last_idx  = r_count - CW'(1);

    assign w_empty     = r_count == '0;
    assign w_direct    = w_empty || (r_item.pp_line < r_first_pp);
    assign w_order_err = !w_empty && (r_item.pp_line <= r_last_pp);
    assign w_full      = r_count == CW'(TABLE_DEPTH);
    assign w_add_ok    = i_cmd.exec && (r_item.op == ldm_pkg::OP_ADD)
                         && !w_order_err && !w_full;

    assign o_stat.need_search = (r_item.op == ldm_pkg::OP_QUERY) && !w_direct;
    assign o_stat.search_go   = w_search_go;

    always_ff @(posedge i_clk) begin
        if (w_add_ok) begin
            r_mem[r_count[IW-1:0]] <= '{pp_line:   r_item.pp_line,
                                        orig_line: r_item.orig_line,
                                        file_id:   r_item.file_id};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_last_pp  <= '0;
            r_base_fid <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base_fid <= i_cfg_wr_data;
            end
            if (w_add_ok) begin
                r_count   <= r_count + CW'(1);
                r_last_pp <= r_item.pp_line;
            end else if (i_cmd.exec && (r_item.op == ldm_pkg::OP_CLEAR)) begin
                r_count   <= '0;
                r_last_pp <= '0;
            end
        end
    end

    always_comb begin
        n_res_exec = '0;
        case (r_item.op)
            ldm_pkg::OP_ADD: begin
                if (w_order_err) begin
                    n_res_exec.status = ldm_pkg::ST_ORDER;
                end else if (w_full) begin
                    n_res_exec.status = ldm_pkg::ST_FULL;
                end else begin
                    n_res_exec.status = ldm_pkg::ST_OK;
                end
            end
            ldm_pkg::OP_QUERY: begin
                n_res_exec.mapped_line    = signed'({2'b00, r_item.pp_line});
                n_res_exec.mapped_file_id = r_base_fid;
            end
            default: begin
                n_res_exec = '0;
            end
        endcase
    end

    // The found entry is at or below the queried line, so the offset cannot go negative.
    assign w_diff = r_item.pp_line - r_rd_data.pp_line;

    always_comb begin
        n_res_fin                = '0;
        n_res_fin.mapped_line    = signed'({2'b00, r_rd_data.orig_line}
                                           + {2'b00, w_diff} - 26'd1);
        n_res_fin.mapped_file_id = r_rd_data.file_id;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (w_add_ok && w_empty) begin
            r_first_pp <= r_item.pp_line;
        end
        if (i_cmd.search_init) begin
            r_lo <= '0;
            r_hi <= w_last_idx[IW-1:0];
        end else if (i_cmd.step) begin
            if (r_rd_data.pp_line > r_item.pp_line) begin
                r_hi <= w_mid - IW'(1);
            end else begin
                r_lo <= w_mid;
            end
        end
        if (i_cmd.exec) begin
            r_res <= n_res_exec;
        end else if (i_cmd.finish) begin
            r_res <= n_res_fin;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

@@ src/line_directive_map.sv @@
// Line directive map: a table of (preprocessed line, original line, file id)
// directives, filled in increasing preprocessed-line order, that maps a line
// back to its original line and file id.
// Input channel: i_in_valid / o_in_ready carry one operation per beat (add,
// query or clear). Output channel: o_out_valid / i_out_ready carry exactly
// one result beat per input beat, in order.
// The block works on one operation at a time. Add, clear and a query that
// falls before the first directive go through the execute state to the done
// state, which loads the result into the output register. A query that
// searches goes from the execute state into a binary search: each probe is
// a read of the entry memory, registered in the search state, and one
// compare in the compare state; once the range holds one entry the result
// is calculated and passed to the done state. The result sits in an output
// register, so the next operation is accepted while a result waits; if the
// receiver stalls, the following result waits in the datapath and no
// further beat is accepted until it moves on. Write base_file_id through
// i_cfg_wr_en / i_cfg_wr_data only while idle; the block does not enforce
// this. Reset empties the table and sets base_file_id to zero; the entry
// memory itself is not cleared, since only written entries are ever read.
`default_nettype none
module line_directive_map #(
    parameter int TABLE_DEPTH = ldm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [7:0]         i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ldm_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ldm_pkg::t_out_item      o_out_data
);

    ldm_pkg::t_cmd  w_cmd;
    ldm_pkg::t_stat w_stat;

    ldm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ldm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_data    (o_out_data)
    );

endmodule
`default_nettype wire

@@ src/ldm_checker.sv @@
`default_nettype none
module ldm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire ldm_pkg::t_out_item o_out_data
);

    // A result beat holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // One operation at a time: the beat after an accept is never accepted at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // A rejected add never carries a mapped line or file id.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ldm_pkg::ST_OK)
        |-> (o_out_data.mapped_line == '0) && (o_out_data.mapped_file_id == '0))
        else $error("rejected add reports a mapping");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ldm_pkg::ST_FULL)
        else $error("undefined status code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind line_directive_map ldm_checker u_ldm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
